// ===== rtl/text_console_engine_defines.svh =====
// Shared assertion macros for the text console engine.
`ifndef TEXT_CONSOLE_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_ENGINE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define TCE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("text console engine: same-cycle check failed");

// Next-cycle implication, checked on every rising edge out of reset.
`define TCE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text console engine: next-cycle check failed");

`endif

// ===== rtl/tce_pkg.sv =====
package tce_pkg;

  // Request kinds carried on the input tuser.
  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_GOTO  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  // Control characters handled by a put request.
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  localparam logic [7:0] BLANK_CHAR = 8'h20;

  // Register indexes (byte address divided by four).
  localparam logic [1:0] REG_ATTR = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;
  localparam logic [1:0] REG_ROWS = 2'd2;

  localparam logic [7:0] ATTR_RESET = 8'd2;
  localparam logic [7:0] COLS_RESET = 8'd80;
  localparam logic [6:0] ROWS_RESET = 7'd25;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the accepted request
    logic exec;        // cursor update and first cell write or read
    logic clear_step;  // blank one cell of the clear sweep
    logic scroll_step; // one step of the scroll sweep
    logic finish;      // blank the cursor cell unless a read, and load the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_clear;
    logic need_scroll;
    logic sweep_last;
  } sts_t;

endpackage

// ===== rtl/tce_cfg.sv =====
module tce_cfg #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [3:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic [7:0]                          attribute,
  output logic [$clog2(MAX_COLS + 1) - 1:0]   eff_cols,
  output logic [$clog2(MAX_ROWS + 1) - 1:0]   eff_rows
);

  localparam int WW = $clog2(MAX_COLS + 1);
  localparam int HW = $clog2(MAX_ROWS + 1);

  logic [7:0] attribute_r;
  logic [7:0] columns_r;
  logic [6:0] rows_r;
  logic       wr_en;

  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attribute_r <= tce_pkg::ATTR_RESET;
      columns_r   <= tce_pkg::COLS_RESET;
      rows_r      <= tce_pkg::ROWS_RESET;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        tce_pkg::REG_ATTR: attribute_r <= pwdata[7:0];
        tce_pkg::REG_COLS: columns_r   <= pwdata[7:0];
        tce_pkg::REG_ROWS: rows_r      <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      tce_pkg::REG_ATTR: prdata = {24'd0, attribute_r};
      tce_pkg::REG_COLS: prdata = {24'd0, columns_r};
      tce_pkg::REG_ROWS: prdata = {25'd0, rows_r};
      default:           prdata = '0;
    endcase
  end

  // Out-of-range geometry is clamped: at least one column and two rows, at most what the store can hold.
  always_comb begin
    if (columns_r == '0) begin
      eff_cols = WW'(1);
    end else if (32'(columns_r) > MAX_COLS) begin
      eff_cols = WW'(MAX_COLS);
    end else begin
      eff_cols = WW'(columns_r);
    end
    if (32'(rows_r) < 2) begin
      eff_rows = HW'(2);
    end else if (32'(rows_r) > MAX_ROWS) begin
      eff_rows = HW'(MAX_ROWS);
    end else begin
      eff_rows = HW'(rows_r);
    end
  end

  assign attribute = attribute_r;

endmodule

// ===== rtl/tce_ctrl.sv =====
`include "text_console_engine_defines.svh"

module tce_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  tce_pkg::sts_t sts,
  output tce_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_CLEAR  = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       can_emit;
  logic       accept;

  // The result register may be refilled in the cycle it is drained.
  assign can_emit  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) || ((state_r == S_FINISH) && can_emit);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.load  = accept;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.is_clear) begin
          state_nxt = S_CLEAR;
        end else if (sts.need_scroll) begin
          state_nxt = S_SCROLL;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.sweep_last) state_nxt = S_FINISH;
      end
      S_SCROLL: begin
        cmd.scroll_step = 1'b1;
        if (sts.sweep_last) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (can_emit) begin
          cmd.finish = 1'b1;
          state_nxt  = accept ? S_EXEC : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  `TCE_ASSERT_NXT(a_accept_starts_exec, accept, state_r == S_EXEC)
  `TCE_ASSERT_NXT(a_finish_fills_result, cmd.finish, out_valid_r)
  `TCE_ASSERT_IMP(a_single_step, 1'b1,
                  $onehot0({cmd.exec, cmd.clear_step, cmd.scroll_step, cmd.finish}))

endmodule

// ===== rtl/tce_datapath.sv =====
`include "text_console_engine_defines.svh"

module tce_datapath #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64,
  parameter int TAB_STOP = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tce_pkg::cmd_t                     cmd,
  output tce_pkg::sts_t                     sts,
  input  logic [7:0]                        attribute,
  input  logic [$clog2(MAX_COLS + 1) - 1:0] eff_cols,
  input  logic [$clog2(MAX_ROWS + 1) - 1:0] eff_rows,
  input  logic [1:0]                        req_type,
  input  logic [7:0]                        char_code,
  input  logic [6:0]                        goto_col,
  input  logic [5:0]                        goto_row,
  input  logic                              keep_col,
  input  logic                              keep_row,
  input  logic [12:0]                       cell_index,
  output logic [6:0]                        cursor_col,
  output logic [5:0]                        cursor_row,
  output logic [12:0]                       cursor_offset,
  output logic [15:0]                       cell_data
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = AW + 1;
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int WW    = $clog2(MAX_COLS + 1);
  localparam int NX_W  = $clog2(MAX_COLS + TAB_STOP);
  localparam int CX_W  = (NX_W > 7) ? NX_W : 7;
  localparam int RX_W  = (ROW_W + 1 > 6) ? ROW_W + 1 : 6;
  localparam int PW    = ROW_W + WW + 1;

  // Request captured at acceptance.
  logic [1:0]        req_type_r;
  logic [7:0]        char_r;
  logic [6:0]        gcol_r;
  logic [5:0]        grow_r;
  logic              kc_r;
  logic              kr_r;
  logic [12:0]       ci_r;

  logic [COL_W-1:0]  cur_col_r;
  logic [ROW_W-1:0]  cur_row_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  n_r;
  logic [CNT_W-1:0]  keep_r;

  logic [15:0]       mem [DEPTH];
  logic [15:0]       rdata_r;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [15:0]       mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;

  logic [NX_W-1:0]   tab_tbl [MAX_COLS];
  logic [CX_W-1:0]   w_m1;
  logic [RX_W-1:0]   h_m1;
  logic [CX_W-1:0]   col_c;
  logic [RX_W-1:0]   row_c;
  logic [CX_W-1:0]   col_nxt;
  logic [RX_W-1:0]   row_nxt;
  logic [CX_W-1:0]   wr_col;
  logic              wr_put;
  logic [15:0]       wr_put_data;
  logic              scroll;
  logic [15:0]       blank;
  logic [ROW_W-1:0]  m_row;
  logic [COL_W-1:0]  m_col;
  logic [PW-1:0]     prod;
  logic              ci_in_range;

  logic [6:0]        out_col_r;
  logic [5:0]        out_row_r;
  logic [12:0]       out_off_r;
  logic [15:0]       out_data_r;

  // Next tab stop for every column.
  for (genvar g = 0; g < MAX_COLS; g++) begin : g_tab
    assign tab_tbl[g] = NX_W'(((g / TAB_STOP) + 1) * TAB_STOP);
  end

  assign blank = {attribute, tce_pkg::BLANK_CHAR};
  assign w_m1  = CX_W'(eff_cols) - CX_W'(1);
  assign h_m1  = RX_W'(eff_rows) - RX_W'(1);

  // The cursor is pulled back on screen before any request acts on it.
  assign col_c = (CX_W'(cur_col_r) > w_m1) ? w_m1 : CX_W'(cur_col_r);
  assign row_c = (RX_W'(cur_row_r) > h_m1) ? h_m1 : RX_W'(cur_row_r);

  always_comb begin
    col_nxt     = col_c;
    row_nxt     = row_c;
    wr_col      = col_c;
    wr_put      = 1'b0;
    wr_put_data = blank;
    scroll      = 1'b0;
    case (req_type_r)
      tce_pkg::REQ_PUT: begin
        case (char_r)
          tce_pkg::CH_BS: begin
            if (col_c != '0) col_nxt = col_c - CX_W'(1);
            wr_col = col_nxt;
            wr_put = 1'b1;
          end
          tce_pkg::CH_TAB: col_nxt = CX_W'(tab_tbl[col_c[COL_W-1:0]]);
          tce_pkg::CH_CR:  col_nxt = '0;
          tce_pkg::CH_LF: begin
            col_nxt = '0;
            row_nxt = row_c + RX_W'(1);
          end
          default: begin
            wr_put      = 1'b1;
            wr_put_data = {attribute, char_r};
            col_nxt     = col_c + CX_W'(1);
          end
        endcase
        if (col_nxt >= CX_W'(eff_cols)) begin
          col_nxt = '0;
          row_nxt = row_nxt + RX_W'(1);
        end
        if (row_nxt >= RX_W'(eff_rows)) begin
          scroll  = 1'b1;
          row_nxt = h_m1;
        end
      end
      tce_pkg::REQ_GOTO: begin
        if (!kc_r) col_nxt = CX_W'(gcol_r);
        if (!kr_r) row_nxt = RX_W'(grow_r);
        if (col_nxt > w_m1) col_nxt = w_m1;
        if (row_nxt > h_m1) row_nxt = h_m1;
      end
      tce_pkg::REQ_CLEAR: begin
        col_nxt = '0;
        row_nxt = '0;
      end
      default: ;
    endcase
  end

  // One address multiplier, shared by the first write and the final blank.
  assign m_row = cmd.finish ? cur_row_r : row_c[ROW_W-1:0];
  assign m_col = cmd.finish ? cur_col_r : wr_col[COL_W-1:0];
  assign prod  = PW'(m_row) * PW'(eff_cols) + PW'(m_col);

  assign cnt_m1      = cnt_r - CNT_W'(1);
  assign ci_in_range = 32'(ci_r) < DEPTH;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = prod[AW-1:0];
    mem_wdata = blank;
    mem_re    = 1'b0;
    mem_raddr = AW'(ci_r);
    if (cmd.exec && wr_put) begin
      mem_we    = 1'b1;
      mem_wdata = wr_put_data;
    end
    if (cmd.exec && (req_type_r == tce_pkg::REQ_READ)) begin
      mem_re = 1'b1;
    end
    if (cmd.clear_step) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_r[AW-1:0];
    end
    // The scroll reads one row ahead and writes the previous step's data.
    if (cmd.scroll_step) begin
      if (cnt_r < keep_r) begin
        mem_re    = 1'b1;
        mem_raddr = AW'(cnt_r + CNT_W'(eff_cols));
      end
      if (cnt_r != '0) begin
        mem_we    = 1'b1;
        mem_waddr = cnt_m1[AW-1:0];
        mem_wdata = (cnt_m1 < keep_r) ? rdata_r : blank;
      end
    end
    if (cmd.finish && (req_type_r != tce_pkg::REQ_READ)) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.exec) begin
      cnt_nxt = '0;
    end else if (cmd.clear_step || cmd.scroll_step) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r <= '0;
      cur_row_r <= '0;
    end else if (cmd.exec) begin
      cur_col_r <= col_nxt[COL_W-1:0];
      cur_row_r <= row_nxt[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    n_r    <= CNT_W'(eff_cols) * CNT_W'(eff_rows);
    keep_r <= n_r - CNT_W'(eff_cols);
    if (cmd.load) begin
      req_type_r <= req_type;
      char_r     <= char_code;
      gcol_r     <= goto_col;
      grow_r     <= goto_row;
      kc_r       <= keep_col;
      kr_r       <= keep_row;
      ci_r       <= cell_index;
    end
    if (cmd.finish) begin
      out_col_r  <= 7'(cur_col_r);
      out_row_r  <= 6'(cur_row_r);
      out_off_r  <= 13'(prod);
      out_data_r <= ((req_type_r == tce_pkg::REQ_READ) && ci_in_range) ? rdata_r : '0;
    end
  end

  assign sts.is_clear    = (req_type_r == tce_pkg::REQ_CLEAR);
  assign sts.need_scroll = scroll;
  assign sts.sweep_last  = cmd.clear_step ? (cnt_r == n_r - CNT_W'(1)) : (cnt_r == n_r);

  assign cursor_col    = out_col_r;
  assign cursor_row    = out_row_r;
  assign cursor_offset = out_off_r;
  assign cell_data     = out_data_r;

  `TCE_ASSERT_IMP(a_scroll_bound, cmd.scroll_step, cnt_r <= n_r)

endmodule

// ===== rtl/text_console_engine.sv =====
// A request passes through a request step, then the cursor-cell blank and result load,
// which registers the result; a clear adds a sweep over every cell and a put that scrolls
// adds a scroll sweep. A new request can be taken in the finish step of the last one, and
// the finish step waits while an undrained result is held; the cell store has one write port.
// Reset (synchronous, active low) homes the cursor, loads the register defaults and
// leaves the cell store contents undefined until cleared or written.
module text_console_engine #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64,
  parameter int TAB_STOP = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // char_code[7:0], goto_col[14:8], goto_row[20:15], keep_col[21], keep_row[22],
  // cell_index[35:23], zero pad[39:36]
  input  logic [39:0] in_tdata,
  // req_type[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // cursor_col[6:0], cursor_row[12:7], cursor_offset[25:13], cell_data[41:26],
  // zero pad[47:42]
  output logic [47:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int WW = $clog2(MAX_COLS + 1);
  localparam int HW = $clog2(MAX_ROWS + 1);

  tce_pkg::cmd_t cmd;
  tce_pkg::sts_t sts;
  logic [7:0]    attribute;
  logic [WW-1:0] eff_cols;
  logic [HW-1:0] eff_rows;
  logic [6:0]    cursor_col;
  logic [5:0]    cursor_row;
  logic [12:0]   cursor_offset;
  logic [15:0]   cell_data;

  assign cfg_pready = 1'b1;

  tce_cfg #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (cfg_psel),
    .penable   (cfg_penable),
    .pwrite    (cfg_pwrite),
    .paddr     (cfg_paddr),
    .pwdata    (cfg_pwdata),
    .prdata    (cfg_prdata),
    .attribute (attribute),
    .eff_cols  (eff_cols),
    .eff_rows  (eff_rows)
  );

  tce_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  tce_datapath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .attribute     (attribute),
    .eff_cols      (eff_cols),
    .eff_rows      (eff_rows),
    .req_type      (in_tuser),
    .char_code     (in_tdata[7:0]),
    .goto_col      (in_tdata[14:8]),
    .goto_row      (in_tdata[20:15]),
    .keep_col      (in_tdata[21]),
    .keep_row      (in_tdata[22]),
    .cell_index    (in_tdata[35:23]),
    .cursor_col    (cursor_col),
    .cursor_row    (cursor_row),
    .cursor_offset (cursor_offset),
    .cell_data     (cell_data)
  );

  assign out_tdata = {6'd0, cell_data, cursor_offset, cursor_row, cursor_col};

endmodule
